FILE: hw/rtl/apc_pkg.sv
package apc_pkg;

	// Default sizes
	parameter int N_STAGES_DEF   = 16;
	parameter int N_CHANNELS_DEF = 2;

	// Item modes
	localparam logic MODE_SAMPLE = 1'b0;
	localparam logic MODE_COEF   = 1'b1;

	// Configuration register indexes
	localparam logic [1:0] REG_STAGE_COUNT = 2'd0;
	localparam logic [1:0] REG_WET_MIX     = 2'd1;
	localparam logic [1:0] REG_OUT_GAIN    = 2'd2;

	// Register reset values
	localparam logic [4:0]  STAGE_COUNT_RST = 5'd10;
	localparam logic [15:0] WET_MIX_RST     = 16'd32768;
	localparam logic [15:0] OUT_GAIN_RST    = 16'd4096;

	// 1.0 in Q1.15
	localparam logic [15:0] MIX_UNITY = 16'd32768;

	typedef struct packed {
		logic               mode;
		logic               channel;
		logic signed [23:0] sample_in;
		logic [3:0]         coef_index;
		logic signed [15:0] coef_value;
	} apc_in_t;

	typedef struct packed {
		logic signed [23:0] sample_out;
		logic               channel_out;
	} apc_out_t;

	// Sample token handed from cell to cell
	typedef struct packed {
		logic               v;
		logic               ch;
		logic signed [23:0] x;
	} apc_tok_t;

	// Coefficient load broadcast to all cells
	typedef struct packed {
		logic               en;
		logic [3:0]         idx;
		logic signed [15:0] val;
	} apc_coef_wr_t;

	// Round a Q1.15-scaled product back to the sample scale
	function automatic logic signed [25:0] rnd15(input logic signed [39:0] p);
		logic signed [40:0] t;
		t = 41'(p) + 41'sd16384;
		return t[40:15];
	endfunction

	function automatic logic signed [23:0] sat24(input logic signed [32:0] v);
		if (v > 33'sd8388607) begin
			return 24'sh7FFFFF;
		end else if (v < -33'sd8388608) begin
			return 24'sh800000;
		end else begin
			return v[23:0];
		end
	endfunction

	function automatic logic signed [25:0] sat26(input logic signed [26:0] v);
		if (v > 27'sd33554431) begin
			return 26'sh1FFFFFF;
		end else if (v < -27'sd33554432) begin
			return 26'sh2000000;
		end else begin
			return v[25:0];
		end
	endfunction

endpackage

FILE: hw/rtl/apc_cell.sv
module apc_cell #(
	parameter int IDX        = 0,
	parameter int N_CHANNELS = apc_pkg::N_CHANNELS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic [4:0]            stage_count,
	input  apc_pkg::apc_coef_wr_t coef_wr,
	input  apc_pkg::apc_tok_t     tok_in,
	output apc_pkg::apc_tok_t     tok_out
);
	import apc_pkg::*;

	localparam int CW = (N_CHANNELS > 1) ? $clog2(N_CHANNELS) : 1;

	logic signed [15:0] coef_q;
	logic signed [25:0] dly_q [N_CHANNELS];

	logic               active;
	logic [CW-1:0]      chi;
	logic signed [39:0] prod_x;
	logic signed [39:0] prod_y;
	logic signed [26:0] ysum;
	logic signed [23:0] ynext;
	logic signed [26:0] dsum;

	// stage 1: a*x
	logic               v_s1;
	logic               ch_s1;
	logic [CW-1:0]      chi_s1;
	logic signed [23:0] x_s1;
	logic signed [39:0] p_s1;
	// stage 2: y = a*x + d
	logic               v_s2;
	logic               ch_s2;
	logic [CW-1:0]      chi_s2;
	logic signed [23:0] x_s2;
	logic signed [23:0] y_s2;
	// stage 3: a*y, delay update at its output
	logic               v_s3;
	logic [CW-1:0]      chi_s3;
	logic signed [23:0] x_s3;
	logic signed [39:0] q_s3;

	// section in use for this sample
	assign active = int'(stage_count) > IDX;
	// channel modulo the number of delay sets
	assign chi = (N_CHANNELS > 1) ? CW'(tok_in.ch) : '0;

	assign prod_x = 40'(coef_q) * 40'(tok_in.x);
	assign prod_y = 40'(coef_q) * 40'(y_s2);
	assign ysum   = 27'(rnd15(p_s1)) + 27'(dly_q[chi_s1]);
	assign ynext  = active ? sat24(33'(ysum)) : x_s1;
	assign dsum   = 27'(x_s3) - 27'(rnd15(q_s3));

	// coefficient of this section
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_q <= '0;
		end else if (coef_wr.en && int'(coef_wr.idx) == IDX) begin
			coef_q <= coef_wr.val;
		end
	end

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= tok_in.v;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		ch_s1  <= tok_in.ch;
		chi_s1 <= chi;
		x_s1   <= tok_in.x;
		p_s1   <= prod_x;

		ch_s2  <= ch_s1;
		chi_s2 <= chi_s1;
		x_s2   <= x_s1;
		y_s2   <= ynext;

		chi_s3 <= chi_s2;
		x_s3   <= x_s2;
		q_s3   <= prod_y;
	end

	// per-channel delay state: d' = x - a*y
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int c = 0; c < N_CHANNELS; c++) begin
				dly_q[c] <= '0;
			end
		end else if (v_s3 && active) begin
			dly_q[chi_s3] <= sat26(dsum);
		end
	end

	assign tok_out.v  = v_s2;
	assign tok_out.ch = ch_s2;
	assign tok_out.x  = y_s2;

endmodule

FILE: hw/rtl/apc_mix.sv
module apc_mix (
	input  logic               clk,
	input  logic signed [23:0] wet,
	input  logic signed [23:0] dry,
	input  logic [15:0]        wet_mix,
	input  logic [15:0]        out_gain,
	output logic signed [23:0] res
);
	import apc_pkg::*;

	logic [15:0]        m_mix;
	logic [15:0]        m_dry;
	logic signed [40:0] pw;
	logic signed [40:0] pd;
	logic signed [20:0] acc_hi;
	logic signed [20:0] acc_lo;
	logic signed [16:0] gain;
	logic signed [59:0] tot;

	logic signed [40:0] pw_s1;
	logic signed [40:0] pd_s1;
	logic signed [40:0] acc_s2;
	logic signed [37:0] ph_s3;
	logic signed [37:0] pl_s3;
	logic signed [23:0] res_s4;

	// mix weights, wet share clamped to unity
	assign m_mix = (wet_mix > MIX_UNITY) ? MIX_UNITY : wet_mix;
	assign m_dry = MIX_UNITY - m_mix;

	assign pw = 41'(wet) * 41'(signed'({1'b0, m_mix}));
	assign pd = 41'(dry) * 41'(signed'({1'b0, m_dry}));

	// gain product split into high and low halves of the accumulator
	assign acc_hi = acc_s2[40:20];
	assign acc_lo = signed'({1'b0, acc_s2[19:0]});
	assign gain   = signed'({1'b0, out_gain});

	assign tot = (60'(ph_s3) <<< 20) + 60'(pl_s3) + 60'sd67108864;

	always_ff @(posedge clk) begin
		pw_s1  <= pw;
		pd_s1  <= pd;
		acc_s2 <= pw_s1 + pd_s1;
		ph_s3  <= 38'(acc_hi) * 38'(gain);
		pl_s3  <= 38'(acc_lo) * 38'(gain);
		res_s4 <= sat24(tot[59:27]);
	end

	assign res = res_s4;

endmodule

FILE: hw/rtl/allpass_cascade_mix.sv
// Each sample passes through the registers of every section cell, then is captured as the wet
// sample, goes through the mix and gain pipeline and then into the output register.
// A new sample is accepted only after the previous result has entered the output register;
// a coefficient load is accepted while idle and goes straight to the cells.
// The cascade always runs its full length; sections past stage_count pass the sample through.
// Reset clears coefficients, delay state and control, and loads the register defaults.
module allpass_cascade_mix #(
	parameter int N_STAGES   = apc_pkg::N_STAGES_DEF,
	parameter int N_CHANNELS = apc_pkg::N_CHANNELS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  apc_pkg::apc_in_t in_data,
	output logic             out_valid,
	input  logic             out_ready,
	output apc_pkg::apc_out_t out_data,
	input  logic             cfg_we,
	input  logic [1:0]       cfg_idx,
	input  logic [15:0]      cfg_data
);
	import apc_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_CHAIN = 4'b0010,
		ST_MIX   = 4'b0100,
		ST_PUSH  = 4'b1000
	} apc_state_t;

	localparam logic [1:0] MIX_LAST = 2'd3;

	apc_state_t         state_q;
	logic [1:0]         cnt_q;
	logic [4:0]         stage_count_q;
	logic [15:0]        wet_mix_q;
	logic [15:0]        out_gain_q;
	logic               start_q;
	logic               chan_q;
	logic signed [23:0] dry_q;
	logic signed [23:0] wet_q;
	logic               out_valid_q;
	apc_out_t           out_q;

	logic               in_xfer;
	logic               out_xfer;
	logic               push;
	logic signed [23:0] mix_res;
	apc_coef_wr_t       coef_wr;
	apc_tok_t           tok [N_STAGES+1];

	assign in_ready = (state_q == ST_IDLE);
	assign in_xfer  = in_valid && in_ready;
	assign out_xfer = out_valid_q && out_ready;
	assign push     = (state_q == ST_PUSH) && (!out_valid_q || out_ready);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stage_count_q <= STAGE_COUNT_RST;
			wet_mix_q     <= WET_MIX_RST;
			out_gain_q    <= OUT_GAIN_RST;
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_STAGE_COUNT: stage_count_q <= cfg_data[4:0];
				REG_WET_MIX:     wet_mix_q     <= cfg_data;
				REG_OUT_GAIN:    out_gain_q    <= cfg_data;
				default: ;
			endcase
		end
	end

	// coefficient load goes straight to the cells
	assign coef_wr.en  = in_xfer && (in_data.mode == MODE_COEF);
	assign coef_wr.idx = in_data.coef_index;
	assign coef_wr.val = in_data.coef_value;

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			start_q <= 1'b0;
		end else begin
			start_q <= in_xfer && (in_data.mode == MODE_SAMPLE);
			case (state_q)
				ST_IDLE: begin
					if (in_xfer && in_data.mode == MODE_SAMPLE) begin
						state_q <= ST_CHAIN;
					end
				end
				ST_CHAIN: begin
					if (tok[N_STAGES].v) begin
						state_q <= ST_MIX;
						cnt_q   <= '0;
					end
				end
				ST_MIX: begin
					cnt_q <= cnt_q + 2'd1;
					if (cnt_q == MIX_LAST) begin
						state_q <= ST_PUSH;
					end
				end
				ST_PUSH: begin
					if (push) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// sample capture and cascade output
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			dry_q  <= in_data.sample_in;
			chan_q <= in_data.channel;
		end
		if (tok[N_STAGES].v) begin
			wet_q <= tok[N_STAGES].x;
		end
	end

	// chain of allpass cells
	assign tok[0].v  = start_q;
	assign tok[0].ch = chan_q;
	assign tok[0].x  = dry_q;

	for (genvar i = 0; i < N_STAGES; i++) begin : g_cell
		apc_cell #(
			.IDX        (i),
			.N_CHANNELS (N_CHANNELS)
		) u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.stage_count (stage_count_q),
			.coef_wr     (coef_wr),
			.tok_in      (tok[i]),
			.tok_out     (tok[i+1])
		);
	end

	apc_mix u_mix (
		.clk      (clk),
		.wet      (wet_q),
		.dry      (dry_q),
		.wet_mix  (wet_mix_q),
		.out_gain (out_gain_q),
		.res      (mix_res)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (push) begin
			out_valid_q <= 1'b1;
		end else if (out_xfer) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			out_q.sample_out  <= mix_res;
			out_q.channel_out <= chan_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// checks
	a_state_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot(state_q))
		else $error("state register not one-hot");

	a_chain_end_in_chain: assert property (@(posedge clk) disable iff (!arst_n)
		tok[N_STAGES].v |-> (state_q == ST_CHAIN))
		else $error("cascade output outside of chain phase");

	a_start_after_sample: assert property (@(posedge clk) disable iff (!arst_n)
		(in_xfer && in_data.mode == MODE_SAMPLE) |=> (start_q && state_q == ST_CHAIN))
		else $error("sample transfer did not launch the cascade");

	a_push_loads_out: assert property (@(posedge clk) disable iff (!arst_n)
		push |=> (out_valid_q && state_q == ST_IDLE))
		else $error("result not registered after push");

endmodule
